[sv/esd_pkg.sv]
// esd_pkg: shared types and constants for the escape sequence decoder
// used by esd_front, esd_queue, esd_back and escape_sequence_decoder
`timescale 1ns / 1ps
`default_nettype none

package esd_pkg;

    localparam int ESD_QUOTE_SLOTS = 4;
    localparam int ESD_QUOTE_W     = 32;
    localparam int ESD_QUEUE_DEPTH = 4;
    localparam int ESD_ADDR_W      = 5;
    localparam int ESD_DATA_W      = 32;

    // register index, paddr[4:2]
    localparam logic [2:0] REG_QUOTE_CHARS      = 3'd0;
    localparam logic [2:0] REG_BACKREF_MODE     = 3'd1;
    localparam logic [2:0] REG_LEAD_FIRST_LOW   = 3'd2;
    localparam logic [2:0] REG_LEAD_FIRST_HIGH  = 3'd3;
    localparam logic [2:0] REG_LEAD_SECOND_LOW  = 3'd4;
    localparam logic [2:0] REG_LEAD_SECOND_HIGH = 3'd5;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DIG0   = 8'h30;
    localparam logic [7:0] CH_DIG1   = 8'h31;
    localparam logic [7:0] CH_DIG7   = 8'h37;
    localparam logic [7:0] CH_DIG9   = 8'h39;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CTRL,
        MODE_HEXSTART,
        MODE_HEX,
        MODE_OCT,
        MODE_TRAIL
    } t_mode;

    typedef struct packed {
        logic [ESD_QUOTE_W-1:0] quote_chars;
        logic                   backref_mode;
        logic [7:0]             lead_first_low;
        logic [7:0]             lead_first_high;
        logic [7:0]             lead_second_low;
        logic [7:0]             lead_second_high;
    } t_cfg;

    // one classified source word
    typedef struct packed {
        logic [7:0] chr;
        logic       last;
        logic       is_zero;
        logic       quoted;
        logic       lead;
        logic       is_bslash;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_x;
        logic       is_c;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic       oct_ok;
        logic       map_ok;
        logic [7:0] map_byte;
        logic       ctrl_ok;
        logic [7:0] ctrl_byte;
    } t_item;

    // decoder state plus up to two result words of one step
    typedef struct packed {
        t_mode      mode;
        logic [7:0] val;
        logic       nz;
        logic       brace;
        logic [1:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_ctx;

endpackage

`default_nettype wire

[sv/escape_sequence_decoder.sv]
// escape_sequence_decoder: top level, register port and front/queue/back
// depends on esd_pkg, esd_front, esd_queue, esd_back
//
//  channel  | direction | handshake                        | payload
//  ---------+-----------+----------------------------------+---------------------------
//  in       | input     | i_in_valid / o_in_stall          | i_in_byte, i_end_of_string
//  out      | output    | o_out_valid / i_out_stall        | o_out_byte, o_run_last
//  register | input     | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// one source word per cycle is taken while the four-entry queue has room
// the back end retires one queued word per cycle while the output is not stalled;
// a two-byte word blocks the next pop until its second byte is loaded, as the output
// register moves one byte a cycle; words pass the queue, then the output register
// synchronous reset clears the decoder state and the queue and resets the registers
// output stall holds the output register; the queue absorbs the front meanwhile
`timescale 1ns / 1ps
`default_nettype none

module escape_sequence_decoder #(
    parameter int QUOTE_SLOTS = esd_pkg::ESD_QUOTE_SLOTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_in_byte,
    input  wire logic                           i_end_of_string,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_out_byte,
    output logic                                o_run_last,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [esd_pkg::ESD_ADDR_W-1:0] paddr,
    input  wire logic [esd_pkg::ESD_DATA_W-1:0] pwdata,
    output logic [esd_pkg::ESD_DATA_W-1:0]      prdata,
    output logic                                pready
);

    esd_pkg::t_cfg  r_cfg;
    esd_pkg::t_cfg  n_cfg;
    esd_pkg::t_item front_item;
    esd_pkg::t_item head_item;
    logic [2:0]     reg_idx;
    logic           wr_en;
    logic           push;
    logic           pop;
    logic           full;
    logic           nonempty;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                esd_pkg::REG_QUOTE_CHARS:      n_cfg.quote_chars      = pwdata;
                esd_pkg::REG_BACKREF_MODE:     n_cfg.backref_mode     = pwdata[0];
                esd_pkg::REG_LEAD_FIRST_LOW:   n_cfg.lead_first_low   = pwdata[7:0];
                esd_pkg::REG_LEAD_FIRST_HIGH:  n_cfg.lead_first_high  = pwdata[7:0];
                esd_pkg::REG_LEAD_SECOND_LOW:  n_cfg.lead_second_low  = pwdata[7:0];
                esd_pkg::REG_LEAD_SECOND_HIGH: n_cfg.lead_second_high = pwdata[7:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            esd_pkg::REG_QUOTE_CHARS:      prdata = r_cfg.quote_chars;
            esd_pkg::REG_BACKREF_MODE:     prdata = {31'd0, r_cfg.backref_mode};
            esd_pkg::REG_LEAD_FIRST_LOW:   prdata = {24'd0, r_cfg.lead_first_low};
            esd_pkg::REG_LEAD_FIRST_HIGH:  prdata = {24'd0, r_cfg.lead_first_high};
            esd_pkg::REG_LEAD_SECOND_LOW:  prdata = {24'd0, r_cfg.lead_second_low};
            esd_pkg::REG_LEAD_SECOND_HIGH: prdata = {24'd0, r_cfg.lead_second_high};
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_chars      <= '0;
            r_cfg.backref_mode     <= 1'b0;
            r_cfg.lead_first_low   <= 8'hFF;
            r_cfg.lead_first_high  <= 8'h00;
            r_cfg.lead_second_low  <= 8'hFF;
            r_cfg.lead_second_high <= 8'h00;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    esd_front #(
        .QUOTE_SLOTS (QUOTE_SLOTS)
    ) u_front (
        .i_in_valid      (i_in_valid),
        .i_in_byte       (i_in_byte),
        .i_end_of_string (i_end_of_string),
        .i_full          (full),
        .i_cfg           (r_cfg),
        .o_in_stall      (o_in_stall),
        .o_push          (push),
        .o_item          (front_item)
    );

    esd_queue #(
        .DEPTH (esd_pkg::ESD_QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (front_item),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head_item)
    );

    esd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_backref_mode (r_cfg.backref_mode),
        .i_head_valid   (nonempty),
        .i_head         (head_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last)
    );

endmodule

`default_nettype wire

[sv/esd_front.sv]
// esd_front: accepts source words and classifies each byte
// depends on esd_pkg; feeds esd_queue
`timescale 1ns / 1ps
`default_nettype none

module esd_front #(
    parameter int QUOTE_SLOTS = esd_pkg::ESD_QUOTE_SLOTS
) (
    input  wire logic          i_in_valid,
    input  wire logic [7:0]    i_in_byte,
    input  wire logic          i_end_of_string,
    input  wire logic          i_full,
    input  wire esd_pkg::t_cfg i_cfg,
    output logic               o_in_stall,
    output logic               o_push,
    output esd_pkg::t_item     o_item
);

    localparam int NUM_SLOTS = (QUOTE_SLOTS < esd_pkg::ESD_QUOTE_W / 8) ?
                               QUOTE_SLOTS : esd_pkg::ESD_QUOTE_W / 8;

    logic [7:0] c;
    logic       quoted;

    assign c          = i_in_byte;
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        quoted = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_cfg.quote_chars[8*i +: 8] != esd_pkg::CH_NUL &&
                i_cfg.quote_chars[8*i +: 8] == c) begin
                quoted = 1'b1;
            end
        end
    end

    always_comb begin
        o_item           = '0;
        o_item.chr       = c;
        o_item.last      = i_end_of_string;
        o_item.is_zero   = (c == esd_pkg::CH_NUL);
        o_item.quoted    = quoted;
        o_item.lead      = (c >= i_cfg.lead_first_low && c <= i_cfg.lead_first_high) ||
                           (c >= i_cfg.lead_second_low && c <= i_cfg.lead_second_high);
        o_item.is_bslash = (c == esd_pkg::CH_BSLASH);
        o_item.is_lbrace = (c == esd_pkg::CH_LBRACE);
        o_item.is_rbrace = (c == esd_pkg::CH_RBRACE);
        o_item.is_x      = (c == esd_pkg::CH_LO_X) || (c == esd_pkg::CH_UP_X);
        o_item.is_c      = (c == esd_pkg::CH_LO_C);
        o_item.oct_ok    = (c >= esd_pkg::CH_DIG0) && (c <= esd_pkg::CH_DIG7);

        // hex digit value
        if (c >= esd_pkg::CH_DIG0 && c <= esd_pkg::CH_DIG9) begin
            o_item.hex_ok  = 1'b1;
            o_item.hex_val = c[3:0];
        end else if ((c >= esd_pkg::CH_UP_A && c <= esd_pkg::CH_UP_F) ||
                     (c >= esd_pkg::CH_LO_A && c <= esd_pkg::CH_LO_F)) begin
            o_item.hex_ok  = 1'b1;
            o_item.hex_val = c[3:0] + 4'd9;
        end

        // control code
        if ((c >= esd_pkg::CH_AT && c <= esd_pkg::CH_USCORE) ||
            (c >= esd_pkg::CH_LO_A && c <= esd_pkg::CH_LO_Z)) begin
            o_item.ctrl_ok   = 1'b1;
            o_item.ctrl_byte = {3'b000, c[4:0]};
        end else if (c == esd_pkg::CH_QMARK) begin
            o_item.ctrl_ok   = 1'b1;
            o_item.ctrl_byte = esd_pkg::CH_DEL;
        end

        // single letter escapes
        o_item.map_ok = 1'b1;
        case (c)
            esd_pkg::CH_LO_A:   o_item.map_byte = esd_pkg::CH_BEL;
            esd_pkg::CH_LO_E:   o_item.map_byte = esd_pkg::CH_ESC;
            esd_pkg::CH_LO_F:   o_item.map_byte = esd_pkg::CH_FF;
            esd_pkg::CH_LO_N:   o_item.map_byte = esd_pkg::CH_LF;
            esd_pkg::CH_LO_R:   o_item.map_byte = esd_pkg::CH_CR;
            esd_pkg::CH_LO_T:   o_item.map_byte = esd_pkg::CH_TAB;
            esd_pkg::CH_LO_V:   o_item.map_byte = esd_pkg::CH_VT;
            esd_pkg::CH_SQUOTE: o_item.map_byte = c;
            esd_pkg::CH_DQUOTE: o_item.map_byte = c;
            esd_pkg::CH_BSLASH: o_item.map_byte = c;
            default: begin
                o_item.map_ok   = 1'b0;
                o_item.map_byte = c;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/esd_queue.sv]
// esd_queue: short queue of classified words between front and back
// depends on esd_pkg
`timescale 1ns / 1ps
`default_nettype none

module esd_queue #(
    parameter int DEPTH = esd_pkg::ESD_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire esd_pkg::t_item i_item,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output esd_pkg::t_item      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esd_pkg::t_item   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_cnt == CNT_W'(DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

[sv/esd_back.sv]
// esd_back: escape state machine and output register
// depends on esd_pkg; takes words from esd_queue
`timescale 1ns / 1ps
`default_nettype none

module esd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_backref_mode,
    input  wire logic           i_head_valid,
    input  wire esd_pkg::t_item i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_run_last
);

    function automatic esd_pkg::t_ctx f_emit(esd_pkg::t_ctx x, logic [7:0] b);
        esd_pkg::t_ctx r;
        r = x;
        if (x.cnt == 2'd0) begin
            r.b0  = b;
            r.cnt = 2'd1;
        end else if (x.cnt == 2'd1) begin
            r.b1  = b;
            r.cnt = 2'd2;
        end
        return r;
    endfunction

    function automatic esd_pkg::t_ctx f_clear(esd_pkg::t_ctx x);
        esd_pkg::t_ctx r;
        r       = x;
        r.val   = '0;
        r.nz    = 1'b0;
        r.brace = 1'b0;
        return r;
    endfunction

    function automatic esd_pkg::t_ctx f_flush(esd_pkg::t_ctx x);
        esd_pkg::t_ctx r;
        r = x;
        if (x.nz) begin
            r = f_emit(r, x.val);
        end
        return f_clear(r);
    endfunction

    function automatic esd_pkg::t_ctx f_add(esd_pkg::t_ctx x, logic [3:0] d, logic hex);
        esd_pkg::t_ctx r;
        r     = x;
        r.val = hex ? {x.val[3:0], d} : {x.val[4:0], d[2:0]};
        r.nz  = x.nz || (d != 4'd0);
        return r;
    endfunction

    function automatic esd_pkg::t_ctx f_normal(esd_pkg::t_ctx x, esd_pkg::t_item it);
        esd_pkg::t_ctx r;
        r = x;
        if (it.is_bslash) begin
            r.mode = esd_pkg::MODE_ESC;
        end else begin
            r      = f_emit(r, it.chr);
            r.mode = it.lead ? esd_pkg::MODE_TRAIL : esd_pkg::MODE_NORMAL;
        end
        return r;
    endfunction

    function automatic esd_pkg::t_ctx f_finish(esd_pkg::t_ctx x);
        esd_pkg::t_ctx r;
        r = x;
        if (x.mode == esd_pkg::MODE_HEX || x.mode == esd_pkg::MODE_OCT) begin
            r = f_flush(r);
        end else if (x.mode == esd_pkg::MODE_ESC) begin
            r = f_emit(r, esd_pkg::CH_BSLASH);
        end
        r.mode = esd_pkg::MODE_NORMAL;
        return f_clear(r);
    endfunction

    function automatic esd_pkg::t_ctx f_hex(esd_pkg::t_ctx x, esd_pkg::t_item it);
        esd_pkg::t_ctx r;
        r = x;
        if (it.hex_ok) begin
            r = f_add(r, it.hex_val, 1'b1);
        end else if (it.is_rbrace && x.brace) begin
            r      = f_flush(r);
            r.mode = esd_pkg::MODE_NORMAL;
        end else begin
            r      = f_flush(r);
            r.mode = esd_pkg::MODE_NORMAL;
            r      = f_normal(r, it);
        end
        return r;
    endfunction

    esd_pkg::t_mode r_mode;
    logic [7:0]     r_val;
    logic           r_nz;
    logic           r_brace;
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_last;
    logic           r_pend_valid;
    logic [7:0]     r_pend_byte;

    esd_pkg::t_mode n_mode;
    logic [7:0]     n_val;
    logic           n_nz;
    logic           n_brace;
    logic           n_out_valid;
    logic [7:0]     n_out_byte;
    logic           n_out_last;
    logic           n_pend_valid;
    logic [7:0]     n_pend_byte;

    esd_pkg::t_ctx  step;
    logic           slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_pop       = i_head_valid && !r_pend_valid && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_out_last;

    always_comb begin
        step       = '0;
        step.mode  = r_mode;
        step.val   = r_val;
        step.nz    = r_nz;
        step.brace = r_brace;
        if (i_head.is_zero) begin
            step = f_finish(step);
        end else begin
            case (r_mode)
                esd_pkg::MODE_ESC: begin
                    step.mode = esd_pkg::MODE_NORMAL;
                    if (i_head.quoted) begin
                        step = f_emit(step, i_head.chr);
                    end else if (i_head.map_ok) begin
                        step = f_emit(step, i_head.map_byte);
                    end else if (i_head.is_c) begin
                        step.mode = esd_pkg::MODE_CTRL;
                    end else if (i_head.is_x) begin
                        step      = f_clear(step);
                        step.mode = esd_pkg::MODE_HEXSTART;
                    end else if (i_head.chr == esd_pkg::CH_DIG0 ||
                                 (i_head.chr >= esd_pkg::CH_DIG1 &&
                                  i_head.chr <= esd_pkg::CH_DIG7 && !i_backref_mode)) begin
                        step      = f_clear(step);
                        step      = f_add(step, {1'b0, i_head.chr[2:0]}, 1'b0);
                        step.mode = esd_pkg::MODE_OCT;
                    end else begin
                        step = f_emit(step, esd_pkg::CH_BSLASH);
                        step = f_emit(step, i_head.chr);
                        if (i_head.lead) begin
                            step.mode = esd_pkg::MODE_TRAIL;
                        end
                    end
                end
                esd_pkg::MODE_CTRL: begin
                    step.mode = esd_pkg::MODE_NORMAL;
                    if (i_head.ctrl_ok) begin
                        step = f_emit(step, i_head.ctrl_byte);
                    end else begin
                        step = f_normal(step, i_head);
                    end
                end
                esd_pkg::MODE_HEXSTART: begin
                    step.mode = esd_pkg::MODE_HEX;
                    if (i_head.is_lbrace) begin
                        step.brace = 1'b1;
                    end else begin
                        step = f_hex(step, i_head);
                    end
                end
                esd_pkg::MODE_HEX: begin
                    step = f_hex(step, i_head);
                end
                esd_pkg::MODE_OCT: begin
                    if (i_head.oct_ok) begin
                        step = f_add(step, {1'b0, i_head.chr[2:0]}, 1'b0);
                    end else begin
                        step      = f_flush(step);
                        step.mode = esd_pkg::MODE_NORMAL;
                        step      = f_normal(step, i_head);
                    end
                end
                esd_pkg::MODE_TRAIL: begin
                    step      = f_emit(step, i_head.chr);
                    step.mode = esd_pkg::MODE_NORMAL;
                end
                default: begin
                    step = f_normal(step, i_head);
                end
            endcase
            if (i_head.last) begin
                step = f_finish(step);
            end
        end
    end

    always_comb begin
        n_mode       = r_mode;
        n_val        = r_val;
        n_nz         = r_nz;
        n_brace      = r_brace;
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        if (r_pend_valid && slot_free) begin
            // second word of a pair
            n_out_valid  = 1'b1;
            n_out_byte   = r_pend_byte;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end else if (o_pop) begin
            n_mode       = step.mode;
            n_val        = step.val;
            n_nz         = step.nz;
            n_brace      = step.brace;
            n_out_valid  = (step.cnt != 2'd0);
            n_out_byte   = step.b0;
            n_out_last   = (step.cnt == 2'd1);
            n_pend_valid = (step.cnt == 2'd2);
            n_pend_byte  = step.b1;
        end else if (slot_free) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= esd_pkg::MODE_NORMAL;
            r_val        <= '0;
            r_nz         <= 1'b0;
            r_brace      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_mode       <= n_mode;
            r_val        <= n_val;
            r_nz         <= n_nz;
            r_brace      <= n_brace;
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte  <= n_out_byte;
        r_out_last  <= n_out_last;
        r_pend_byte <= n_pend_byte;
    end

endmodule

`default_nettype wire
